>>> sv/ilst_pkg.sv
// ilst_pkg: types, codes and sizes shared by the indexed insert/delete list.
// No dependencies; imported by ilst_cell and indexed_insert_delete_list.
package ilst_pkg;

    // List capacity. The position field is exactly wide enough to index it.
    localparam int CAPACITY = 64;
    localparam int POS_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // Request kinds
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_APPEND = 2'd2;
    localparam logic [1:0] KIND_DELETE = 2'd3;

    // Response status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     hit;
        logic [1:0]               status;
        logic [CNT_W-1:0]         length;
    } rsp_t;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

>>> sv/ilst_cell.sv
// ilst_cell: one list slot; shifts up, shifts down, loads or holds each cycle.
// Depends on ilst_pkg for the command struct and widths.
module ilst_cell
    import ilst_pkg::*;
(
    input  logic              clk,
    input  logic [POS_W-1:0]  index,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] lower_data,
    input  logic [DATA_W-1:0] upper_data,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] sel_data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Pick the next slot value from the broadcast command
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (index > ctrl.pos)
            begin
                data_next = lower_data;
            end
            else if (index == ctrl.pos)
            begin
                data_next = ctrl.value;
            end
        end
        else if (ctrl.del)
        begin
            if (index >= ctrl.pos)
            begin
                data_next = upper_data;
            end
        end
    end

    // Hold slot payload; no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // Drive the slot onto the read OR tree only when addressed
    assign sel_data = (index == ctrl.pos) ? data_reg : '0;

endmodule

>>> sv/indexed_insert_delete_list.sv
// indexed_insert_delete_list: top level, request decode, entry count and response register.
// Depends on ilst_pkg and a row of ilst_cell slots.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  request | req_valid/req_ready  | req_data  (kind, position, value)
//  response| rsp_valid/rsp_ready  | rsp_data  (read_value, hit, status, length)
//
// All slots shift or hold in parallel at the accepting edge, which also
// loads the response register; rsp_valid rises next cycle.
// A new request is taken every cycle while the response register is empty or
// being drained; a stalled response holds req_ready low.
// Reset clears the entry count and the response valid; slot contents are
// undefined until written and are never read beyond the length.
module indexed_insert_delete_list
    import ilst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              req_accept;

    logic              dec_ins;
    logic              dec_del;
    logic              dec_hit;
    logic [1:0]        dec_status;
    logic [POS_W-1:0]  dec_pos;
    logic [CNT_W-1:0]  pos_ext;
    cell_ctrl_t        ctrl;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_sel  [CAPACITY];
    logic [DATA_W-1:0] read_or;

    assign req_ready  = !rsp_valid_reg || rsp_ready;
    assign req_accept = req_valid && req_ready;
    assign pos_ext    = {1'b0, req_data.position};

    // Decode the request against the current length
    always_comb
    begin
        dec_ins    = 1'b0;
        dec_del    = 1'b0;
        dec_hit    = 1'b0;
        dec_status = ST_DONE;
        dec_pos    = req_data.position;
        count_next = count_reg;
        case (req_data.kind)
            KIND_READ:
            begin
                if (pos_ext < count_reg)
                begin
                    dec_hit = 1'b1;
                end
                else
                begin
                    dec_status = ST_RANGE;
                end
            end
            KIND_INSERT:
            begin
                if (pos_ext > count_reg)
                begin
                    dec_status = ST_RANGE;
                end
                else if (count_reg == CNT_FULL)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_ins    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_APPEND:
            begin
                if (count_reg == CNT_FULL)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_ins    = 1'b1;
                    dec_pos    = count_reg[POS_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_DELETE:
            begin
                if (pos_ext < count_reg)
                begin
                    dec_del    = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    dec_status = ST_RANGE;
                end
            end
            default:
            begin
                dec_status = ST_RANGE;
            end
        endcase
    end

    // Broadcast the shift command only on an accepted request
    always_comb
    begin
        ctrl.ins   = dec_ins && req_accept;
        ctrl.del   = dec_del && req_accept;
        ctrl.pos   = dec_pos;
        ctrl.value = req_data.value;
    end

    // Row of slots, each linked to its neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;
        if (i == 0)
        begin : g_first
            assign lower = req_data.value;
        end
        else
        begin : g_mid_lo
            assign lower = cell_data[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = cell_data[i];
        end
        else
        begin : g_mid_hi
            assign upper = cell_data[i+1];
        end
        ilst_cell u_cell (
            .clk        (clk),
            .index      (POS_W'(i)),
            .ctrl       (ctrl),
            .lower_data (lower),
            .upper_data (upper),
            .data       (cell_data[i]),
            .sel_data   (cell_sel[i])
        );
    end

    // Combine the addressed slot onto the read bus
    always_comb
    begin
        read_or = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            read_or = read_or | cell_sel[k];
        end
    end

    // Assemble the response
    always_comb
    begin
        rsp_next.read_value = dec_hit ? read_or : '1;
        rsp_next.hit        = dec_hit;
        rsp_next.status     = dec_status;
        rsp_next.length     = count_next;
    end

    // Advance the count and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the response payload
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Length never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above capacity");

    // Length only moves on an accepted request
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !req_accept |=> $stable(count_reg))
        else $error("entry count changed without a request");

    // Every accepted request yields a response carrying the new length
    a_rsp_length: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> (rsp_valid && rsp_data.length == count_reg))
        else $error("response missing or length mismatch");

    // A hit is always a completed read
    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.hit) |-> (rsp_data.status == ST_DONE))
        else $error("hit with non-done status");

endmodule
